### rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands for the RTL in this folder.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion lbl failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion lbl failed");

`endif

### rtl/core/ple_pkg.sv
// ----------------------------------------------------------------------------
// Positional list engine package
// Command codes, status codes and fixed field widths.
// ----------------------------------------------------------------------------
package ple_pkg;

  localparam int unsigned CmdW = 3;
  localparam int unsigned PosW = 6;
  localparam int unsigned ValW = 32;
  localparam int unsigned StW  = 3;

  // Command codes carried on the input beat.
  typedef enum logic [CmdW-1:0] {
    CMD_FRONT_INS = 3'd0,
    CMD_BACK_INS  = 3'd1,
    CMD_POS_INS   = 3'd2,
    CMD_DELETE    = 3'd3,
    CMD_SEARCH    = 3'd4,
    CMD_CLEAR     = 3'd5,
    CMD_FWD_READ  = 3'd6,
    CMD_REV_READ  = 3'd7
  } cmd_e;

  // Status codes returned on the result beat.
  localparam logic [StW-1:0] ST_OK       = 3'd0;
  localparam logic [StW-1:0] ST_RANGE    = 3'd1;
  localparam logic [StW-1:0] ST_EMPTY    = 3'd2;
  localparam logic [StW-1:0] ST_NOTFOUND = 3'd3;
  localparam logic [StW-1:0] ST_FULL     = 3'd4;

endpackage

### rtl/core/ple_mem.sv
// ----------------------------------------------------------------------------
// Positional list element memory
// One write port and one read port with registered, enable-held read data.
// ----------------------------------------------------------------------------
module ple_mem #(
  parameter int unsigned Depth = 32,
  parameter int unsigned AddrW = 5,
  parameter int unsigned DataW = 32
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [DataW-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic [DataW-1:0] rd_data_o
);

  logic [DataW-1:0] mem_q [Depth];
  logic [DataW-1:0] rd_data_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Read port; the data holds while no read is issued.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

### rtl/core/positional_list_engine_top.sv
// ----------------------------------------------------------------------------
// Positional list engine
// Bounded ordered list of signed 32-bit values with insert, delete, search,
// clear and full read-out commands, driven by a sequencer over one memory.
// ----------------------------------------------------------------------------
// One command is taken at a time; in_ready_o is low while a command runs.
// All work goes through a single element memory with one read and one write
// port, so the cost is set by how many elements a command must move or visit.
// An insert or delete moves every element behind its position one by one, a
// search visits elements from the front until it hits or passes the end, and
// a read visits every element. Any command also waits while the result side
// stalls.
// A read returns one result beat per element with last_o on the final one;
// every other command returns a single beat with last_o set.
module positional_list_engine_top #(
  parameter int unsigned CAPACITY = 32
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [ple_pkg::CmdW-1:0] cmd_i,
  input  logic [ple_pkg::PosW-1:0] position_i,
  input  logic signed [ple_pkg::ValW-1:0] value_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [ple_pkg::StW-1:0]  status_o,
  output logic signed [ple_pkg::ValW-1:0] value_out_o,
  output logic [ple_pkg::PosW-1:0] position_out_o,
  output logic [ple_pkg::PosW-1:0] element_total_o,
  output logic                     last_o
);

  import ple_pkg::*;

  `include "assert_macros.svh"

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned XW = ((CW > PosW) ? CW : PosW) + 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS,
    S_DEL,
    S_SRCH,
    S_READ,
    S_FIN
  } state_e;

  // Control state.
  state_e          state_q, state_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic [AW-1:0]   idx_q, idx_d;
  logic [AW-1:0]   ptr_q, ptr_d;
  logic            more_q, more_d;
  logic            dv_q, dv_d;
  logic [AW-1:0]   k_q, k_d;
  logic [CW-1:0]   j_q, j_d;
  logic            rev_q, rev_d;
  logic            out_valid_q, out_valid_d;

  // Payload state.
  logic [ValW-1:0] val_q, val_d;
  logic [StW-1:0]  st_q, st_d;
  logic [PosW-1:0] found_q, found_d;
  logic [StW-1:0]  o_st_q, o_st_d;
  logic [ValW-1:0] o_val_q, o_val_d;
  logic [PosW-1:0] o_pos_q, o_pos_d;
  logic [PosW-1:0] o_tot_q, o_tot_d;
  logic            o_last_q, o_last_d;

  // Memory port signals.
  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  logic [ValW-1:0] mem_wdata;
  logic            mem_re;
  logic [AW-1:0]   mem_raddr;
  logic [ValW-1:0] mem_rdata;

  logic            in_acc;
  logic            out_free;
  logic [XW-1:0]   pos_x;
  logic [XW-1:0]   cnt_x;
  logic            full;
  logic [AW-1:0]   cnt_m1;
  logic [AW-1:0]   rd_idx;
  logic [CW-1:0]   k_p1;

  ple_mem #(
    .Depth (CAPACITY),
    .AddrW (AW),
    .DataW (ValW)
  ) u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (mem_we),
    .wr_addr_i (mem_waddr),
    .wr_data_i (mem_wdata),
    .rd_en_i   (mem_re),
    .rd_addr_i (mem_raddr),
    .rd_data_o (mem_rdata)
  );

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign pos_x      = XW'(position_i);
  assign cnt_x      = XW'(cnt_q);
  assign full       = (cnt_q >= CW'(CAPACITY));
  assign cnt_m1     = AW'(cnt_q - CW'(1));
  assign rd_idx     = rev_q ? AW'(cnt_m1 - AW'(j_q)) : AW'(j_q);
  assign k_p1       = CW'(k_q) + CW'(1);

  // Sequencer: decodes a command, then walks the memory one element a cycle while the result side does not stall.
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    ptr_d       = ptr_q;
    more_d      = more_q;
    dv_d        = dv_q;
    k_d         = k_q;
    j_d         = j_q;
    rev_d       = rev_q;
    val_d       = val_q;
    st_d        = st_q;
    found_d     = found_q;
    out_valid_d = out_valid_q && !out_ready_i;
    o_st_d      = o_st_q;
    o_val_d     = o_val_q;
    o_pos_d     = o_pos_q;
    o_tot_d     = o_tot_q;
    o_last_d    = o_last_q;
    mem_we      = 1'b0;
    mem_waddr   = '0;
    mem_wdata   = mem_rdata;
    mem_re      = 1'b0;
    mem_raddr   = rd_idx;

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          val_d   = value_i;
          st_d    = ST_OK;
          found_d = '0;
          dv_d    = 1'b0;
          j_d     = '0;
          state_d = S_FIN;
          case (cmd_e'(cmd_i))
            CMD_FRONT_INS: begin
              if (full) begin
                st_d = ST_FULL;
              end else begin
                idx_d   = '0;
                ptr_d   = cnt_m1;
                more_d  = (cnt_q != '0);
                state_d = S_INS;
              end
            end
            CMD_BACK_INS: begin
              if (full) begin
                st_d = ST_FULL;
              end else begin
                idx_d   = AW'(cnt_q);
                ptr_d   = cnt_m1;
                more_d  = 1'b0;
                state_d = S_INS;
              end
            end
            CMD_POS_INS: begin
              if (pos_x == '0 || pos_x > cnt_x + XW'(1)) begin
                st_d = ST_RANGE;
              end else if (full) begin
                st_d = ST_FULL;
              end else begin
                idx_d   = AW'(position_i - PosW'(1));
                ptr_d   = cnt_m1;
                more_d  = (pos_x <= cnt_x);
                state_d = S_INS;
              end
            end
            CMD_DELETE: begin
              if (pos_x == '0 || pos_x > cnt_x) begin
                st_d = ST_RANGE;
              end else begin
                ptr_d   = AW'(position_i);
                more_d  = (pos_x < cnt_x);
                state_d = S_DEL;
              end
            end
            CMD_SEARCH: begin
              if (cnt_q == '0) begin
                st_d = ST_EMPTY;
              end else begin
                rev_d   = 1'b0;
                state_d = S_SRCH;
              end
            end
            CMD_CLEAR: begin
              cnt_d = '0;
            end
            CMD_FWD_READ, CMD_REV_READ: begin
              if (cnt_q == '0) begin
                st_d = ST_EMPTY;
              end else begin
                rev_d   = (cmd_e'(cmd_i) == CMD_REV_READ);
                state_d = S_READ;
              end
            end
            default: begin
              st_d = ST_OK;
            end
          endcase
        end
      end

      // Shift elements up by one from the back, then place the new value.
      S_INS: begin
        if (dv_q) begin
          mem_we    = 1'b1;
          mem_waddr = AW'(k_q + AW'(1));
        end
        if (more_q) begin
          mem_re    = 1'b1;
          mem_raddr = ptr_q;
          dv_d      = 1'b1;
          k_d       = ptr_q;
          more_d    = (ptr_q != idx_q);
          ptr_d     = AW'(ptr_q - AW'(1));
        end else begin
          dv_d = 1'b0;
          if (!dv_q) begin
            mem_we    = 1'b1;
            mem_waddr = idx_q;
            mem_wdata = val_q;
            cnt_d     = CW'(cnt_q + CW'(1));
            state_d   = S_FIN;
          end
        end
      end

      // Shift the elements behind the deleted one down by one.
      S_DEL: begin
        if (dv_q) begin
          mem_we    = 1'b1;
          mem_waddr = AW'(k_q - AW'(1));
        end
        if (more_q) begin
          mem_re    = 1'b1;
          mem_raddr = ptr_q;
          dv_d      = 1'b1;
          k_d       = ptr_q;
          more_d    = (ptr_q != cnt_m1);
          ptr_d     = AW'(ptr_q + AW'(1));
        end else begin
          dv_d = 1'b0;
          if (!dv_q) begin
            cnt_d   = CW'(cnt_q - CW'(1));
            state_d = S_FIN;
          end
        end
      end

      // Compare each element read back against the key, front first.
      S_SRCH: begin
        if (dv_q && mem_rdata == val_q) begin
          st_d    = ST_OK;
          found_d = PosW'(k_p1);
          state_d = S_FIN;
        end else if (j_q < cnt_q) begin
          mem_re = 1'b1;
          dv_d   = 1'b1;
          k_d    = rd_idx;
          j_d    = CW'(j_q + CW'(1));
        end else if (!dv_q) begin
          st_d    = ST_NOTFOUND;
          state_d = S_FIN;
        end else begin
          dv_d = 1'b0;
        end
      end

      // Stream elements to the result register, one beat per element.
      S_READ: begin
        if (dv_q && out_free) begin
          out_valid_d = 1'b1;
          o_st_d      = ST_OK;
          o_val_d     = mem_rdata;
          o_pos_d     = PosW'(k_p1);
          o_tot_d     = PosW'(cnt_q);
          o_last_d    = rev_q ? (k_q == '0) : (k_q == cnt_m1);
          dv_d        = 1'b0;
          if (o_last_d) begin
            state_d = S_IDLE;
          end
        end
        if ((j_q < cnt_q) && (!dv_q || out_free)) begin
          mem_re = 1'b1;
          dv_d   = 1'b1;
          k_d    = rd_idx;
          j_d    = CW'(j_q + CW'(1));
        end
      end

      // Single result beat for every non-read command and for a read of an empty list.
      S_FIN: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          o_st_d      = st_q;
          o_val_d     = '0;
          o_pos_d     = found_q;
          o_tot_d     = PosW'(cnt_q);
          o_last_d    = 1'b1;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      idx_q       <= '0;
      ptr_q       <= '0;
      more_q      <= 1'b0;
      dv_q        <= 1'b0;
      k_q         <= '0;
      j_q         <= '0;
      rev_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      idx_q       <= idx_d;
      ptr_q       <= ptr_d;
      more_q      <= more_d;
      dv_q        <= dv_d;
      k_q         <= k_d;
      j_q         <= j_d;
      rev_q       <= rev_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    val_q    <= val_d;
    st_q     <= st_d;
    found_q  <= found_d;
    o_st_q   <= o_st_d;
    o_val_q  <= o_val_d;
    o_pos_q  <= o_pos_d;
    o_tot_q  <= o_tot_d;
    o_last_q <= o_last_d;
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = o_st_q;
  assign value_out_o     = o_val_q;
  assign position_out_o  = o_pos_q;
  assign element_total_o = o_tot_q;
  assign last_o          = o_last_q;

  // Checks on the sequencer.
  `ASSERT_IMP(a_cnt_bound, clk_i, rst_ni, 1'b1, cnt_q <= CW'(CAPACITY))
  `ASSERT_NXT(a_busy_after_cmd, clk_i, rst_ni, in_acc, !in_ready_o)
  `ASSERT_IMP(a_wr_in_range, clk_i, rst_ni, mem_we, mem_waddr < AW'(CAPACITY - 1) ||
              mem_waddr == AW'(CAPACITY - 1))
  `ASSERT_NXT(a_del_count, clk_i, rst_ni, state_q == S_DEL,
              cnt_q == $past(cnt_q) || cnt_q + CW'(1) == $past(cnt_q))

endmodule

### bench/list_check_pkg.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Positional list checker
// Shadow copy of the ordered list that predicts every result beat of the
// engine, keeps the expected beats in order and compares them field by field.
// ----------------------------------------------------------------------------
package list_check_pkg;

  import ple_pkg::*;

  localparam int unsigned LIST_CAP = 32;

  // One expected result beat.
  typedef struct {
    logic [StW-1:0]         status;
    logic signed [ValW-1:0] value;
    logic [PosW-1:0]        position;
    logic [PosW-1:0]        total;
    logic                   last;
  } list_beat_t;

  class list_scoreboard;

    logic signed [ValW-1:0] elems[$];
    list_beat_t             want_q[$];
    int unsigned            errors;
    int unsigned            beats_checked;
    int unsigned            cmds_noted;
    int unsigned            full_rejects;
    int unsigned            times_full;
    int unsigned            cmd_hits[8];

    function int unsigned size();
      return elems.size();
    endfunction

    function logic signed [ValW-1:0] element(int unsigned idx);
      return elems[idx];
    endfunction

    function int unsigned pending();
      return want_q.size();
    endfunction

    // Queue one expected beat; the total is the list size after the command.
    function void push_beat(logic [StW-1:0] st, logic signed [ValW-1:0] v,
                            int unsigned pos, logic lst);
      list_beat_t b;
      b.status   = st;
      b.value    = v;
      b.position = pos[PosW-1:0];
      b.total    = PosW'(elems.size());
      b.last     = lst;
      want_q.push_back(b);
    endfunction

    // Apply one accepted command to the shadow list and predict its beats.
    function void note_command(cmd_e c, logic [PosW-1:0] p, logic signed [ValW-1:0] v);
      int unsigned    n;
      int unsigned    pi;
      int unsigned    found;
      int unsigned    i;
      int unsigned    idx;
      logic [StW-1:0] st;
      n     = elems.size();
      pi    = p;
      found = 0;
      st    = ST_OK;
      cmds_noted++;
      cmd_hits[c]++;
      case (c)
        CMD_FRONT_INS, CMD_BACK_INS, CMD_POS_INS: begin
          // A bad position is reported ahead of a full list.
          if (c == CMD_POS_INS && (pi < 1 || pi > n + 1)) begin
            st = ST_RANGE;
          end else if (n >= LIST_CAP) begin
            st = ST_FULL;
            full_rejects++;
          end else begin
            if (c == CMD_FRONT_INS) elems.push_front(v);
            else if (c == CMD_BACK_INS) elems.push_back(v);
            else elems.insert(pi - 1, v);
            if (elems.size() == LIST_CAP) times_full++;
          end
        end
        CMD_DELETE: begin
          if (pi < 1 || pi > n) st = ST_RANGE;
          else elems.delete(pi - 1);
        end
        CMD_SEARCH: begin
          if (n == 0) begin
            st = ST_EMPTY;
          end else begin
            st = ST_NOTFOUND;
            for (i = 0; i < n; i++) begin
              if (elems[i] == v) begin
                st    = ST_OK;
                found = i + 1;
                break;
              end
            end
          end
        end
        CMD_CLEAR: begin
          elems.delete();
        end
        default: begin
          // Reads return one beat per element, front or back first.
          if (n == 0) begin
            st = ST_EMPTY;
          end else begin
            for (i = 0; i < n; i++) begin
              idx = (c == CMD_FWD_READ) ? i : n - 1 - i;
              push_beat(ST_OK, elems[idx], idx + 1, i == n - 1);
            end
            return;
          end
        end
      endcase
      push_beat(st, '0, found, 1'b1);
    endfunction

    task report_mismatch(string msg);
      $display("MISMATCH: %s", msg);
      errors++;
    endtask

    task cmp_field(string name, logic [ValW-1:0] got, logic [ValW-1:0] want);
      if (got !== want) begin
        report_mismatch($sformatf("beat %0d field %s: got %h, expected %h",
                                  beats_checked, name, got, want));
      end
    endtask

    // Compare one accepted result beat with the oldest expected one.
    task check_beat(logic [StW-1:0] st, logic signed [ValW-1:0] v,
                    logic [PosW-1:0] pos, logic [PosW-1:0] tot, logic lst);
      list_beat_t b;
      if (want_q.size() == 0) begin
        report_mismatch($sformatf("result beat %0d arrived with nothing expected",
                                  beats_checked));
      end else begin
        b = want_q.pop_front();
        cmp_field("status", ValW'(st), ValW'(b.status));
        cmp_field("value_out", v, b.value);
        cmp_field("position_out", ValW'(pos), ValW'(b.position));
        cmp_field("element_total", ValW'(tot), ValW'(b.total));
        cmp_field("last", ValW'(lst), ValW'(b.last));
      end
      beats_checked++;
    endtask

  endclass

endpackage

### bench/positional_list_engine_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Positional list engine testbench
// Drives list commands over a valid/ready channel, directed corner cases
// first and then long random sequences that grow and shrink the list, while
// a shadow list predicts every result beat for in-order comparison.
// ----------------------------------------------------------------------------
module positional_list_engine_top_tb;

  import ple_pkg::*;
  import list_check_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 450;
  localparam int unsigned CALM_ITEMS   = 60;
  localparam int unsigned HOLD_CYCLES  = 250;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned LIMIT_CYCLES = 600000;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   in_valid_r;
  logic                   in_ready_o;
  logic [CmdW-1:0]        cmd_r;
  logic [PosW-1:0]        position_r;
  logic signed [ValW-1:0] value_r;
  logic                   out_valid_o;
  logic                   out_ready_r;
  logic [StW-1:0]         status_o;
  logic signed [ValW-1:0] value_out_o;
  logic [PosW-1:0]        position_out_o;
  logic [PosW-1:0]        element_total_o;
  logic                   last_o;

  list_scoreboard sb = new();
  bit             calm;
  bit             hold_req;
  bit             growing = 1'b1;
  int unsigned    cycle_count;

  positional_list_engine_top #(
    .CAPACITY(LIST_CAP)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_r),
    .in_ready_o     (in_ready_o),
    .cmd_i          (cmd_r),
    .position_i     (position_r),
    .value_i        (value_r),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_r),
    .status_o       (status_o),
    .value_out_o    (value_out_o),
    .position_out_o (position_out_o),
    .element_total_o(element_total_o),
    .last_o         (last_o)
  );

  // Clock with a 12 ns period.
  initial clk_i = 1'b0;
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles, %0d beats still expected", cycle_count,
               sb.pending());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Every accepted result beat goes to the checker.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_r) begin
      sb.check_beat(status_o, value_out_o, position_out_o, element_total_o, last_o);
    end
  end

  // Result side: random stall bursts, plus one long hold-off on request.
  initial begin
    out_ready_r <= 1'b1;
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready_r <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        out_ready_r <= 1'b1;
        @(posedge clk_i);
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        out_ready_r <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk_i);
        out_ready_r <= 1'b1;
        @(posedge clk_i);
      end else begin
        out_ready_r <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  // Offer one command beat, after an optional idle burst, and wait for it
  // to be taken.
  task automatic issue(cmd_e c, logic [PosW-1:0] p, logic signed [ValW-1:0] v);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid_r <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_r <= 1'b1;
    cmd_r      <= c;
    position_r <= p;
    value_r    <= v;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_command(c, p, v);
  endtask

  // Values mix stored elements (for duplicates and search hits), extremes
  // and full random words.
  function automatic logic signed [ValW-1:0] pick_value(int unsigned hit_pct);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (sb.size() != 0 && roll < hit_pct) begin
      return sb.element($urandom_range(0, sb.size() - 1));
    end else if (roll < hit_pct + 20) begin
      case ($urandom_range(0, 4))
        0: return 32'sh8000_0000;
        1: return 32'sh7FFF_FFFF;
        2: return 32'sh0000_0000;
        3: return -32'sd1;
        default: return 32'sd1;
      endcase
    end
    return $urandom;
  endfunction

  // Random command: the list alternates between growing to capacity and
  // shrinking, with some noise on top.
  task automatic random_command();
    int unsigned     n;
    int unsigned     roll;
    cmd_e            c;
    logic [PosW-1:0] p;
    n    = sb.size();
    roll = $urandom_range(0, 99);
    if (growing && n == LIST_CAP && $urandom_range(0, 3) == 0) growing = 1'b0;
    if (!growing && n <= 1) growing = 1'b1;
    p = PosW'($urandom_range(0, LIST_CAP));
    if (roll < 10) begin
      c = cmd_e'($urandom_range(0, 7));
    end else if (growing) begin
      if (roll < 30) c = CMD_FRONT_INS;
      else if (roll < 50) c = CMD_BACK_INS;
      else if (roll < 75) begin
        c = CMD_POS_INS;
        p = PosW'($urandom_range(1, (n + 1 > LIST_CAP) ? LIST_CAP : n + 1));
      end else if (roll < 83) c = CMD_SEARCH;
      else if (roll < 90) c = (roll[0]) ? CMD_FWD_READ : CMD_REV_READ;
      else begin
        c = CMD_DELETE;
        if (n != 0) p = PosW'($urandom_range(1, n));
      end
    end else begin
      if (roll < 45) begin
        c = CMD_DELETE;
        if (n != 0) p = PosW'($urandom_range(1, n));
      end else if (roll < 55) begin
        c = CMD_DELETE;
        p = PosW'((n < LIST_CAP && roll[0]) ? $urandom_range(n + 1, LIST_CAP) : 0);
      end else if (roll < 65) c = CMD_SEARCH;
      else if (roll < 75) c = (roll[0]) ? CMD_FWD_READ : CMD_REV_READ;
      else if (roll < 78) c = CMD_CLEAR;
      else if (roll < 90) begin
        c = cmd_e'($urandom_range(0, 2));
        if (n != 0) p = PosW'($urandom_range(1, (n + 1 > LIST_CAP) ? LIST_CAP : n + 1));
      end else begin
        c = CMD_POS_INS;
        p = PosW'((n + 2 <= LIST_CAP && roll[0]) ? $urandom_range(n + 2, LIST_CAP) : 0);
      end
    end
    issue(c, p, pick_value((c == CMD_SEARCH) ? 65 : 35));
  endtask

  // Main sequence.
  initial begin
    rst_ni     = 1'b0;
    in_valid_r <= 1'b0;
    cmd_r      <= CMD_FRONT_INS;
    position_r <= '0;
    value_r    <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Empty list: search, both reads and deletes are refused.
    issue(CMD_SEARCH, 6'd0, 32'sd5);
    issue(CMD_FWD_READ, 6'd0, 32'sd0);
    issue(CMD_REV_READ, 6'd0, 32'sd0);
    issue(CMD_DELETE, 6'd1, 32'sd0);
    issue(CMD_DELETE, 6'd0, 32'sd0);
    // Position insert outside 1 to count+1.
    issue(CMD_POS_INS, 6'd0, 32'sd9);
    issue(CMD_POS_INS, 6'd2, 32'sd9);
    issue(CMD_POS_INS, 6'd32, 32'sd9);
    // Build a short list with extreme values at every insert point.
    issue(CMD_POS_INS, 6'd1, 32'sh8000_0000);
    issue(CMD_FRONT_INS, 6'd0, 32'sh7FFF_FFFF);
    issue(CMD_BACK_INS, 6'd0, 32'sd0);
    issue(CMD_BACK_INS, 6'd0, -32'sd1);
    issue(CMD_POS_INS, 6'd5, 32'sh5A5A_5A5A);
    issue(CMD_POS_INS, 6'd3, 32'sh1234_5678);
    // Search hits, a miss, and both read directions.
    issue(CMD_SEARCH, 6'd0, 32'sd0);
    issue(CMD_SEARCH, 6'd0, -32'sd1);
    issue(CMD_SEARCH, 6'd0, 32'sd77);
    issue(CMD_FWD_READ, 6'd0, 32'sd0);
    issue(CMD_REV_READ, 6'd0, 32'sd0);
    // Deletes past the end, at the back, at the front and in the middle.
    issue(CMD_DELETE, 6'd7, 32'sd0);
    issue(CMD_DELETE, 6'd6, 32'sd0);
    issue(CMD_DELETE, 6'd1, 32'sd0);
    issue(CMD_DELETE, 6'd2, 32'sd0);
    issue(CMD_CLEAR, 6'd0, 32'sd0);
    issue(CMD_SEARCH, 6'd0, 32'sd0);

    // Random part; the long hold-off lands early, with the sender still busy.
    hold_req = 1'b1;
    for (int unsigned k = 0; k < RANDOM_ITEMS; k++) begin
      calm = (k >= RANDOM_ITEMS - CALM_ITEMS) || (k % 100 >= 85);
      random_command();
    end
    in_valid_r <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Covered %0d commands: %0d inserts, %0d deletes, %0d searches,",
             sb.cmds_noted,
             sb.cmd_hits[CMD_FRONT_INS] + sb.cmd_hits[CMD_BACK_INS] + sb.cmd_hits[CMD_POS_INS],
             sb.cmd_hits[CMD_DELETE], sb.cmd_hits[CMD_SEARCH]);
    $display("%0d clears and %0d reads; checked %0d result beats.",
             sb.cmd_hits[CMD_CLEAR], sb.cmd_hits[CMD_FWD_READ] + sb.cmd_hits[CMD_REV_READ],
             sb.beats_checked);
    $display("The list reached capacity %0d times and %0d inserts were refused.",
             sb.times_full, sb.full_rejects);
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### positional_list_engine_top.f
+incdir+rtl/core
rtl/core/ple_pkg.sv
rtl/core/ple_mem.sv
rtl/core/positional_list_engine_top.sv
bench/list_check_pkg.sv
bench/positional_list_engine_top_tb.sv
